FILE: design/keyed_concurrency_limiter_assert.svh
// Assertion macros for the keyed concurrency limiter.
// They sample on the rising edge of clk and stay quiet while rst is high.
`ifndef KEYED_CONCURRENCY_LIMITER_ASSERT_SVH
`define KEYED_CONCURRENCY_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/kcl_pkg.sv
`default_nettype none

package kcl_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_W      = 64;
  localparam int COUNT_W    = 16;
  localparam int KEYS_W     = 5;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Operation codes.
  localparam logic FUNC_ACQUIRE = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GRANTED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KEY_AT_LIMIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN      = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PER_KEY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT     = 2'd1;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/kcl_controller.sv
`default_nettype none

module kcl_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  kcl_pkg::dp_status_t stat,
  output logic               busy,
  output kcl_pkg::ctrl_cmd_t cmd
);

  kcl_pkg::ctrl_state_t state;
  kcl_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kcl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kcl_pkg::S_IDLE: begin
        if (start) begin
          state_next = kcl_pkg::S_SCAN;
        end
      end
      kcl_pkg::S_SCAN: begin
        if (stat.scan_last) begin
          state_next = kcl_pkg::S_COMMIT;
        end
      end
      kcl_pkg::S_COMMIT: begin
        state_next = kcl_pkg::S_IDLE;
      end
      default: begin
        state_next = kcl_pkg::S_IDLE;
      end
    endcase
  end

  assign busy       = (state != kcl_pkg::S_IDLE);
  assign cmd.load   = (state == kcl_pkg::S_IDLE) && start;
  assign cmd.scan   = (state == kcl_pkg::S_SCAN);
  assign cmd.commit = (state == kcl_pkg::S_COMMIT);

endmodule

`default_nettype wire

FILE: design/kcl_datapath.sv
`default_nettype none

module kcl_datapath #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kcl_pkg::ctrl_cmd_t               cmd,
  output kcl_pkg::dp_status_t              stat,
  input  logic                             cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             func,
  input  logic [kcl_pkg::KEY_W-1:0]        key_id,
  output logic                             done,
  output logic [kcl_pkg::STATUS_W-1:0]     status,
  output logic [kcl_pkg::COUNT_W-1:0]      count_after,
  output logic [kcl_pkg::KEYS_W-1:0]       keys_active
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > kcl_pkg::KEYS_W) ? CNT_W : kcl_pkg::KEYS_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] DEPTH    = CNT_W'(TABLE_ENTRIES);

  // Configuration registers.
  logic [kcl_pkg::COUNT_W-1:0] per_key_limit;
  logic [kcl_pkg::KEYS_W-1:0]  key_limit;

  // Table state. Keys and counts live in memory; valid bits are flip-flops.
  logic [TABLE_ENTRIES-1:0]    entry_valid;
  logic [kcl_pkg::KEY_W-1:0]   key_mem [TABLE_ENTRIES];
  logic [kcl_pkg::COUNT_W-1:0] cnt_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0]            active;

  // Operation being worked on.
  logic                        op_func;
  logic [kcl_pkg::KEY_W-1:0]   op_key;

  // Scan pipeline: read issue, then compare in the cycle after.
  logic [CNT_W-1:0]            iss;
  logic                        cmp_vld;
  logic [IDX_W-1:0]            cmp_idx;
  logic [kcl_pkg::KEY_W-1:0]   rd_key;
  logic [kcl_pkg::COUNT_W-1:0] rd_cnt;
  logic                        rd_en;

  // Scan results.
  logic                        hit;
  logic [IDX_W-1:0]            hit_idx;
  logic [kcl_pkg::COUNT_W-1:0] hit_cnt;
  logic                        free_found;
  logic [IDX_W-1:0]            free_idx;

  // Commit decision.
  logic                        new_key_ok;
  logic                        mem_we;
  logic [IDX_W-1:0]            wr_addr;
  logic [kcl_pkg::COUNT_W-1:0] wr_cnt;
  logic                        valid_set;
  logic                        valid_clr;
  logic [CNT_W-1:0]            active_next;
  logic [kcl_pkg::STATUS_W-1:0] res_status;
  logic [kcl_pkg::COUNT_W-1:0] res_cnt;

  logic cmp_valid_bit;
  logic cmp_key_eq;

  assign rd_en          = cmd.scan && (iss < DEPTH);
  assign cmp_valid_bit  = entry_valid[cmp_idx];
  assign cmp_key_eq     = (rd_key == op_key);
  assign stat.scan_last = cmp_vld && (cmp_idx == LAST_IDX);

  // Key and count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= op_key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_key <= key_mem[iss[IDX_W-1:0]];
      rd_cnt <= cnt_mem[iss[IDX_W-1:0]];
    end
  end

  // Control state of the scan and the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      per_key_limit <= kcl_pkg::COUNT_W'(1);
      key_limit     <= kcl_pkg::KEYS_W'(16);
      entry_valid   <= '0;
      active        <= '0;
      iss           <= '0;
      cmp_vld       <= 1'b0;
      hit           <= 1'b0;
      free_found    <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cfg_we) begin
        unique case (cfg_index)
          kcl_pkg::CFG_PER_KEY_LIMIT: per_key_limit <= cfg_data;
          kcl_pkg::CFG_KEY_LIMIT:     key_limit     <= cfg_data[kcl_pkg::KEYS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        iss        <= '0;
        cmp_vld    <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan) begin
        if (rd_en) begin
          iss     <= iss + 1'b1;
          cmp_vld <= 1'b1;
        end else begin
          cmp_vld <= 1'b0;
        end
        if (cmp_vld) begin
          if (cmp_valid_bit && cmp_key_eq && !hit) begin
            hit <= 1'b1;
          end
          if (!cmp_valid_bit && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end else begin
        cmp_vld <= 1'b0;
      end
      if (cmd.commit) begin
        active <= active_next;
        if (valid_set) begin
          entry_valid[free_idx] <= 1'b1;
        end
        if (valid_clr) begin
          entry_valid[hit_idx] <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func;
      op_key  <= key_id;
    end
    if (rd_en) begin
      cmp_idx <= iss[IDX_W-1:0];
    end
    if (cmd.scan && cmp_vld) begin
      if (cmp_valid_bit && cmp_key_eq && !hit) begin
        hit_idx <= cmp_idx;
        hit_cnt <= rd_cnt;
      end
      if (!cmp_valid_bit && !free_found) begin
        free_idx <= cmp_idx;
      end
    end
    if (cmd.commit) begin
      status      <= res_status;
      count_after <= res_cnt;
      keys_active <= kcl_pkg::KEYS_W'(active_next);
    end
  end

  // Decision made at the end of the scan.
  assign new_key_ok = free_found && (CMP_W'(active) < CMP_W'(key_limit));

  always_comb begin
    mem_we      = 1'b0;
    wr_addr     = hit_idx;
    wr_cnt      = hit_cnt;
    valid_set   = 1'b0;
    valid_clr   = 1'b0;
    active_next = active;
    res_status  = kcl_pkg::ST_GRANTED;
    res_cnt     = '0;
    if (op_func == kcl_pkg::FUNC_ACQUIRE) begin
      if (!hit) begin
        if (new_key_ok) begin
          res_status  = kcl_pkg::ST_GRANTED;
          res_cnt     = kcl_pkg::COUNT_W'(1);
          wr_addr     = free_idx;
          wr_cnt      = kcl_pkg::COUNT_W'(1);
          mem_we      = cmd.commit;
          valid_set   = 1'b1;
          active_next = active + 1'b1;
        end else begin
          res_status = kcl_pkg::ST_TABLE_FULL;
        end
      end else if (hit_cnt >= per_key_limit) begin
        res_status = kcl_pkg::ST_KEY_AT_LIMIT;
        res_cnt    = hit_cnt;
      end else begin
        res_status = kcl_pkg::ST_GRANTED;
        res_cnt    = hit_cnt + kcl_pkg::COUNT_W'(1);
        wr_cnt     = hit_cnt + kcl_pkg::COUNT_W'(1);
        mem_we     = cmd.commit;
      end
    end else begin
      if (!hit) begin
        res_status = kcl_pkg::ST_UNKNOWN;
      end else if (hit_cnt <= kcl_pkg::COUNT_W'(1)) begin
        res_status = kcl_pkg::ST_RELEASED;
        valid_clr  = 1'b1;
        if (active != '0) begin
          active_next = active - 1'b1;
        end
      end else begin
        res_status = kcl_pkg::ST_RELEASED;
        res_cnt    = hit_cnt - kcl_pkg::COUNT_W'(1);
        wr_cnt     = hit_cnt - kcl_pkg::COUNT_W'(1);
        mem_we     = cmd.commit;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/keyed_concurrency_limiter.sv
// Flow: a request is accepted while idle, the table is scanned (one read per entry, then the
// compare of the last), and the decision is committed; done then shows the registered result,
// which is taken at the edge that ends the done cycle. A new request is not accepted until
// the previous one has been committed.
// Reset (rst, synchronous, active high) empties the table and restores the limits
// to their defaults; the result strobe cannot be stalled by the receiver.
`default_nettype none

`include "keyed_concurrency_limiter_assert.svh"

module keyed_concurrency_limiter #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [kcl_pkg::KEY_W-1:0]      key_id,
  output logic                           done,
  output logic [kcl_pkg::STATUS_W-1:0]   status,
  output logic [kcl_pkg::COUNT_W-1:0]    count_after,
  output logic [kcl_pkg::KEYS_W-1:0]     keys_active,
  input  logic                           cfg_we,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The controller sequences each request through three phases: it loads the
  // request, scans every table entry while looking for the key and for the
  // lowest free entry, and then commits the decision in the commit state.
  kcl_pkg::ctrl_cmd_t  cmd;
  kcl_pkg::dp_status_t stat;

  kcl_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the configuration registers, the key and count memory,
  // the valid bits and the active key count. Results are registered in the
  // commit cycle and shown for exactly one cycle under done.
  kcl_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .key_id      (key_id),
    .done        (done),
    .status      (status),
    .count_after (count_after),
    .keys_active (keys_active)
  );

  // A load command is only issued for a request that is really accepted.
  `KCL_ASSERT_SAME(a_load_on_accept, cmd.load, start && !busy, "load without an accepted request")
  // An accepted request keeps the block busy in the following cycle.
  `KCL_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after an accepted request")
  // Every commit produces a result strobe in the next cycle.
  `KCL_ASSERT_NEXT(a_done_after_commit, cmd.commit, done, "commit without a result")
  // A result strobe lasts one cycle, and the block is idle while it shows, so it is
  // busy afterwards exactly when a request was presented during the strobe.
  `KCL_ASSERT_NEXT(a_done_single, done, !done && (busy == $past(start)), "result strobe held or block state wrong after a result")

endmodule

`default_nettype wire
